// ===== rtl/mbps_pkg.sv =====
// Shared constants, register codes and structs of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int CHUNK_BYTES = 4096;
	localparam int WIN_DEPTH   = MAX_PATTERN;
	localparam int IDX_W       = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
	localparam int LEN_W       = 5;
	localparam int CHUNK_W     = $clog2(CHUNK_BYTES);
	localparam int ADDR_W      = 64;
	localparam int DATA_W      = 64;
	localparam int MASK_W      = 16;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_WILDCARD_MASK  = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_REGION_BASE    = 3'd4,
		REG_LIST_MODE      = 3'd5
	} reg_idx_t;

	// Pattern pre-aligned to window slots: slot k holds the byte that must sit k bytes
	// back from the newest byte, care[k] says whether slot k is compared at all.
	typedef struct packed {
		logic [WIN_DEPTH-1:0][7:0] pat;
		logic [WIN_DEPTH-1:0]      care;
		logic [FILL_W-1:0]         len;
		logic [IDX_W-1:0]          len_m1;
		logic [ADDR_W-1:0]         base;
		logic                      listing;
	} scan_cfg_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
		logic              done;
	} scan_res_t;

endpackage

// ===== rtl/mbps_cfg.sv =====
// Configuration registers and the registered, window-aligned pattern.
`timescale 1ns / 1ps

module mbps_cfg
	import mbps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output scan_cfg_t            cfg
);

	logic [DATA_W-1:0] pat_lo_q;
	logic [DATA_W-1:0] pat_hi_q;
	logic [MASK_W-1:0] mask_q;
	logic [LEN_W-1:0]  plen_q;
	logic [ADDR_W-1:0] base_q;
	logic              list_q;

	logic [15:0][7:0]  pat_all;
	logic [FILL_W-1:0] len_eff;
	logic [IDX_W-1:0]  len_m1;
	logic [IDX_W-1:0]  src;
	scan_cfg_t         cfg_next;
	scan_cfg_t         cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			mask_q   <= '0;
			plen_q   <= LEN_W'(1);
			base_q   <= '0;
			list_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_PATTERN_LOW:    pat_lo_q <= cfg_data;
				REG_PATTERN_HIGH:   pat_hi_q <= cfg_data;
				REG_WILDCARD_MASK:  mask_q   <= cfg_data[MASK_W-1:0];
				REG_PATTERN_LENGTH: plen_q   <= cfg_data[LEN_W-1:0];
				REG_REGION_BASE:    base_q   <= cfg_data;
				REG_LIST_MODE:      list_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pat_all = {pat_hi_q, pat_lo_q};
		if (plen_q == '0) begin
			len_eff = FILL_W'(1);
		end else if (plen_q > LEN_W'(MAX_PATTERN)) begin
			len_eff = FILL_W'(MAX_PATTERN);
		end else begin
			len_eff = FILL_W'(plen_q);
		end
		len_m1 = IDX_W'(len_eff - FILL_W'(1));
		src    = '0;

		cfg_next         = '0;
		cfg_next.len     = len_eff;
		cfg_next.len_m1  = len_m1;
		cfg_next.base    = base_q;
		cfg_next.listing = list_q;
		// pattern byte j lines up with window slot len-1-j
		for (int k = 0; k < WIN_DEPTH; k++) begin
			src = len_m1 - IDX_W'(k);
			if (FILL_W'(k) < len_eff) begin
				cfg_next.pat[k]  = pat_all[src];
				cfg_next.care[k] = !mask_q[src];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pat: '0, care: WIN_DEPTH'(1), len: FILL_W'(1), len_m1: '0,
				base: '0, listing: 1'b0};
		end else begin
			cfg_q <= cfg_next;
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/mbps_scan.sv =====
// Input register, sliding window, chunk and region tracking, and the window compare.
`timescale 1ns / 1ps

module mbps_scan
	import mbps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [7:0] data_byte,
	input  logic      region_end,
	input  scan_cfg_t cfg,
	input  logic      room,
	output logic      push,
	output scan_res_t res
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;

	logic [WIN_DEPTH-1:0][7:0] win_q;
	logic [FILL_W-1:0]         fill_q;
	logic [CHUNK_W-1:0]        chunk_q;
	logic [ADDR_W-1:0]         offset_q;
	logic                      matched_q;
	logic                      stopped_q;

	logic [WIN_DEPTH-1:0][7:0] win_next;
	logic [FILL_W-1:0]         fill_next;
	logic                      cmp_ok;
	logic                      hit;
	logic                      chunk_last;
	logic                      go;
	logic                      accept;

	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;
	assign go       = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= region_end;
		end
	end

	always_comb begin
		win_next[0] = byte_s1;
		for (int i = 1; i < WIN_DEPTH; i++) begin
			win_next[i] = win_q[i-1];
		end
		fill_next = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
		cmp_ok    = 1'b1;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			if (cfg.care[k] && (cfg.pat[k] != win_next[k])) begin
				cmp_ok = 1'b0;
			end
		end
		hit        = cmp_ok && (fill_next >= cfg.len) && !(cfg.listing && matched_q);
		chunk_last = (chunk_q == CHUNK_W'(CHUNK_BYTES - 1));
	end

	assign push      = go && !stopped_q && (hit || last_s1);
	assign res.found = hit;
	assign res.addr  = hit ? (cfg.base + offset_q - ADDR_W'(cfg.len_m1)) : '0;
	assign res.done  = last_s1 || !cfg.listing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			fill_q    <= '0;
			chunk_q   <= '0;
			offset_q  <= '0;
			matched_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (go) begin
			if (!stopped_q) begin
				win_q <= win_next;
			end
			// end of region wipes all region state, stopped or not
			if (last_s1) begin
				fill_q    <= '0;
				chunk_q   <= '0;
				offset_q  <= '0;
				matched_q <= 1'b0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				offset_q <= offset_q + ADDR_W'(1);
				if (chunk_last) begin
					chunk_q   <= '0;
					fill_q    <= '0;
					matched_q <= 1'b0;
				end else begin
					chunk_q   <= chunk_q + CHUNK_W'(1);
					fill_q    <= fill_next;
					matched_q <= matched_q || hit;
				end
				if (hit && !cfg.listing) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_DEPTH))
		else $error("window fill above window depth");

	a_chunk_restart: assert property (@(posedge clk) disable iff (!arst_n)
		go && !stopped_q && chunk_last |=> fill_q == '0 && !matched_q && chunk_q == '0)
		else $error("chunk boundary did not restart matching");

	a_partial_only_listing: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.found && !res.done |-> cfg.listing && !last_s1)
		else $error("unfinished match result outside list mode");

	a_no_push_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		go && hit && !last_s1 && !cfg.listing && !stopped_q |=> !push)
		else $error("result after first-mode stop");
`endif

endmodule

// ===== rtl/mbps_outq.sv =====
// Two-entry result queue that decouples the scan from output stalls.
`timescale 1ns / 1ps

module mbps_outq
	import mbps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scan_res_t         res,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [ADDR_W-1:0] match_address,
	output logic              scan_done
);

	scan_res_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       pop;
	scan_res_t  head;

	assign room      = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign head      = ent_q[rd_q];

	assign found         = head.found;
	assign match_address = head.addr;
	assign scan_done     = head.done;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result pushed into full queue");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_q == rd_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/masked_byte_pattern_scanner_unit.sv =====
// Top level of the masked byte pattern scanner.
//
//  channel | valid     | flow      | payload
//  --------+-----------+-----------+-------------------------------------
//  in      | in_valid  | in_stall  | data_byte, region_end
//  out     | out_valid | out_stall | found, match_address, scan_done
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while the result queue has room; a result goes through the input register, then
// the window compare into the result queue, and is presented from the head of that queue.
// arst_n clears configuration to its defaults, the window and all region state.
// A two-entry result queue absorbs output stalls; in_stall rises only once it is full
// and the input register holds a byte. cfg_ready is always high.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_unit
	import mbps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 region_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [ADDR_W-1:0]    match_address,
	output logic                 scan_done,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	scan_cfg_t cfg;
	scan_res_t res;
	logic      push;
	logic      room;

	mbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbps_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.region_end (region_end),
		.cfg        (cfg),
		.room       (room),
		.push       (push),
		.res        (res)
	);

	mbps_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.res           (res),
		.room          (room),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.match_address (match_address),
		.scan_done     (scan_done)
	);

endmodule
